// ===== rtl/plm_pkg.sv =====
// Shared types and constants for the persistent limit monitor.
// No dependencies; compiled first.
package plm_pkg;

  // Field widths
  localparam int unsigned LevelW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned NumLevels = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Level bit positions within every per-level mask
  localparam int unsigned BitLl = 0;
  localparam int unsigned BitLw = 1;
  localparam int unsigned BitUw = 2;
  localparam int unsigned BitUl = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLowerLimit   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLowerWarning = 3'd1;
  localparam logic [CfgIdxW-1:0] RegUpperWarning = 3'd2;
  localparam logic [CfgIdxW-1:0] RegUpperLimit   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLevelEnable  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTestOnlyMask = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPersistMs    = 3'd6;

  // Reset values of the configuration registers
  localparam logic [LevelW-1:0]    RstLowerLimit   = 16'd6000;
  localparam logic [LevelW-1:0]    RstLowerWarning = 16'd7000;
  localparam logic [LevelW-1:0]    RstUpperWarning = 16'd13000;
  localparam logic [LevelW-1:0]    RstUpperLimit   = 16'd14000;
  localparam logic [NumLevels-1:0] RstLevelEnable  = 4'hF;
  localparam logic [NumLevels-1:0] RstTestOnlyMask = 4'hF;
  localparam logic [LevelW-1:0]    RstPersistMs    = 16'd250;

  typedef logic [NumLevels-1:0] level_mask_t;

  // Current configuration, handed from the register file to the datapath
  typedef struct packed {
    logic [LevelW-1:0] lower_limit;
    logic [LevelW-1:0] lower_warning;
    logic [LevelW-1:0] upper_warning;
    logic [LevelW-1:0] upper_limit;
    level_mask_t       level_enable;
    level_mask_t       test_only_mask;
    logic [LevelW-1:0] persist_ms;
  } plm_cfg_t;

endpackage

// ===== rtl/plm_if.sv =====
// Valid/ready channel interfaces for sample items and result items.
// Depends on plm_pkg.
interface plm_sample_if
  import plm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] sample_value;
  logic              test_running;
  logic [TimeW-1:0]  now_ms;

  modport source (output valid, sample_value, test_running, now_ms, input ready);
  modport sink   (input valid, sample_value, test_running, now_ms, output ready);
endinterface

interface plm_result_if
  import plm_pkg::*;
  ();
  logic        valid;
  logic        ready;
  level_mask_t armed_mask;
  level_mask_t alarm_mask;

  modport source (output valid, armed_mask, alarm_mask, input ready);
  modport sink   (input valid, armed_mask, alarm_mask, output ready);
endinterface

// ===== rtl/plm_cfg.sv =====
// Configuration register file of the persistent limit monitor.
// Depends on plm_pkg; feeds plm_core with a plm_cfg_t.
module plm_cfg
  import plm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output plm_cfg_t            cfg
);

  // Load reset values, then take writes by index; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower_limit    <= RstLowerLimit;
      cfg.lower_warning  <= RstLowerWarning;
      cfg.upper_warning  <= RstUpperWarning;
      cfg.upper_limit    <= RstUpperLimit;
      cfg.level_enable   <= RstLevelEnable;
      cfg.test_only_mask <= RstTestOnlyMask;
      cfg.persist_ms     <= RstPersistMs;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        RegLowerLimit:   cfg.lower_limit    <= cfg_data[LevelW-1:0];
        RegLowerWarning: cfg.lower_warning  <= cfg_data[LevelW-1:0];
        RegUpperWarning: cfg.upper_warning  <= cfg_data[LevelW-1:0];
        RegUpperLimit:   cfg.upper_limit    <= cfg_data[LevelW-1:0];
        RegLevelEnable:  cfg.level_enable   <= cfg_data[NumLevels-1:0];
        RegTestOnlyMask: cfg.test_only_mask <= cfg_data[NumLevels-1:0];
        RegPersistMs:    cfg.persist_ms     <= cfg_data[LevelW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/plm_core.sv =====
// Datapath of the persistent limit monitor: input register, level compare,
// persistence check with per-level arm state, and result register.
// Depends on plm_pkg and the channel interfaces in plm_if.
module plm_core
  import plm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  plm_cfg_t           cfg,
  plm_sample_if.sink         sample,
  plm_result_if.source       result
);

  // Input register
  logic              s1_valid;
  logic [LevelW-1:0] s1_value;
  logic              s1_test;
  logic [TimeW-1:0]  s1_now;
  logic              s1_move;

  // Per-level state
  level_mask_t      armed;
  level_mask_t      armed_next;
  logic [TimeW-1:0] arm_time [NumLevels];
  level_mask_t      arm_load;

  // Result register
  logic        out_valid;
  level_mask_t out_armed;
  level_mask_t out_alarm;

  level_mask_t raw;
  level_mask_t holds;
  level_mask_t alarm_next;
  logic [TimeW-1:0] elapsed [NumLevels];

  // Advance the input register whenever the result register is free or drains
  assign s1_move      = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || s1_move;

  // Capture an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_value <= sample.sample_value;
      s1_test  <= sample.test_running;
      s1_now   <= sample.now_ms;
    end
  end

  // Compare against the four levels and gate by enable and test mode
  always_comb begin
    raw[BitLl] = s1_value <= cfg.lower_limit;
    raw[BitLw] = s1_value <= cfg.lower_warning;
    raw[BitUw] = s1_value >= cfg.upper_warning;
    raw[BitUl] = s1_value >= cfg.upper_limit;
    holds = raw & cfg.level_enable & ~(cfg.test_only_mask & {NumLevels{~s1_test}});
  end

  // Arm on first hold, alarm once the wrapping elapsed time reaches the delay
  always_comb begin
    armed_next = armed;
    arm_load   = '0;
    alarm_next = '0;
    for (int i = 0; i < NumLevels; i++) begin
      elapsed[i] = s1_now - arm_time[i];
      if (holds[i]) begin
        if (armed[i]) begin
          alarm_next[i] = elapsed[i] >= {{(TimeW-LevelW){1'b0}}, cfg.persist_ms};
        end else begin
          armed_next[i] = 1'b1;
          arm_load[i]   = 1'b1;
        end
      end else begin
        armed_next[i] = 1'b0;
      end
    end
  end

  // Update arm state as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
    end else if (s1_move) begin
      armed <= armed_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NumLevels; i++) begin
      if (s1_move && arm_load[i]) begin
        arm_time[i] <= s1_now;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_armed <= armed_next;
      out_alarm <= alarm_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.armed_mask = out_armed;
  assign result.alarm_mask = out_alarm;

  // An alarm is only raised on a level that was already armed
  a_alarm_needs_arm: assert property (@(posedge clk) disable iff (rst)
    s1_move |-> ((alarm_next & ~armed) == '0))
    else $error("alarm raised on a level that was not armed");

  // A level with an alarm stays armed in the same result
  a_alarm_implies_armed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_alarm & ~out_armed) == '0))
    else $error("alarm bit set without armed bit");

  // The reported armed mask is the stored state after that item
  a_armed_tracks: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> (out_armed == armed))
    else $error("reported armed mask differs from arm state");

  // A stalled input item holds its place
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> (s1_valid && $stable(s1_now) && $stable(s1_value)))
    else $error("input register lost a stalled item");

endmodule

// ===== rtl/persistent_limit_monitor.sv =====
// Persistent limit monitor: one sensor channel checked against four levels
// with a persistence delay per level. One sample item is taken every clock
// cycle while not stalled; the input register takes it at the accepting edge
// and passes it on to the result register, which presents its result.
// Back-pressure on the result channel stalls the sample channel
// only once both registers are full. The throughput is set by the arm-state
// update, which reads and writes the per-level flags and arm times in the
// same cycle for each item. Configuration writes take effect at the next
// clock edge and are meant to be made while no item is in flight.
// Depends on plm_pkg, plm_if, plm_cfg and plm_core.
module persistent_limit_monitor
  import plm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  plm_sample_if.sink          sample,
  plm_result_if.source        result,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  plm_cfg_t cfg;

  // Register file
  plm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Datapath
  plm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .sample (sample),
    .result (result)
  );

endmodule

// ===== verif/persistent_limit_monitor_tb.sv =====
// Self-checking bench for persistent_limit_monitor: drives sample items, predicts
// the armed and alarm masks per item and checks every result item in order.
// Depends on plm_pkg, plm_if and the persistent_limit_monitor RTL.
module persistent_limit_monitor_tb;
  import plm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic [LevelW-1:0] value;
    logic              testing;
    logic [TimeW-1:0]  stamp;
  } sample_t;

  typedef struct packed {
    level_mask_t armed;
    level_mask_t alarm;
  } masks_t;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  plm_sample_if smp ();
  plm_result_if res ();

  persistent_limit_monitor u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp),
    .result    (res),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: configuration copy, armed flags and arm times
  plm_cfg_t         level_cfg;
  level_mask_t      armed_now;
  logic [TimeW-1:0] armed_at [NumLevels];

  sample_t     pending_samples [$];
  masks_t      due_masks [$];
  masks_t      oldest_due;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fault_count;
  logic [TimeW-1:0] stamp_ms;

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Work out the masks that one accepted sample item produces
  function automatic masks_t judge_sample(sample_t s);
    level_mask_t      raw;
    masks_t           m;
    logic [TimeW-1:0] elapsed;
    logic             holds;
    m.alarm       = '0;
    raw[BitLl]    = s.value <= level_cfg.lower_limit;
    raw[BitLw]    = s.value <= level_cfg.lower_warning;
    raw[BitUw]    = s.value >= level_cfg.upper_warning;
    raw[BitUl]    = s.value >= level_cfg.upper_limit;
    for (int i = 0; i < NumLevels; i++) begin
      holds = raw[i] && level_cfg.level_enable[i] &&
              !(level_cfg.test_only_mask[i] && !s.testing);
      if (holds) begin
        if (armed_now[i]) begin
          elapsed = s.stamp - armed_at[i];
          if (elapsed >= {{(TimeW-LevelW){1'b0}}, level_cfg.persist_ms}) m.alarm[i] = 1'b1;
        end else begin
          armed_now[i] = 1'b1;
          armed_at[i]  = s.stamp;
        end
      end else begin
        armed_now[i] = 1'b0;
      end
    end
    m.armed = armed_now;
    return m;
  endfunction

  // Driver: offer the next queued sample item, hold it until taken
  always @(posedge clk) begin
    if (rst) begin
      smp.valid <= 1'b0;
    end else begin
      if (smp.valid && smp.ready) begin
        due_masks.push_back(judge_sample('{smp.sample_value, smp.test_running, smp.now_ms}));
      end
      if (!smp.valid || smp.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          sample_t nxt;
          nxt = pending_samples.pop_front();
          smp.sample_value <= nxt.value;
          smp.test_running <= nxt.testing;
          smp.now_ms       <= nxt.stamp;
          smp.valid        <= 1'b1;
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result item against the oldest prediction
  always @(posedge clk) begin
    if (res.valid && res.ready) begin
      if (due_masks.size() == 0) begin
        $display("%0t: unexpected result, armed %b alarm %b", $time, res.armed_mask,
                 res.alarm_mask);
        fault_count++;
      end else begin
        oldest_due = due_masks.pop_front();
        if (res.armed_mask !== oldest_due.armed) begin
          $display("%0t: armed_mask expected %b actual %b", $time, oldest_due.armed,
                   res.armed_mask);
          fault_count++;
        end
        if (res.alarm_mask !== oldest_due.alarm) begin
          $display("%0t: alarm_mask expected %b actual %b", $time, oldest_due.alarm,
                   res.alarm_mask);
          fault_count++;
        end
      end
    end
    res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      RegLowerLimit:   level_cfg.lower_limit    = data;
      RegLowerWarning: level_cfg.lower_warning  = data;
      RegUpperWarning: level_cfg.upper_warning  = data;
      RegUpperLimit:   level_cfg.upper_limit    = data;
      RegLevelEnable:  level_cfg.level_enable   = data[NumLevels-1:0];
      RegTestOnlyMask: level_cfg.test_only_mask = data[NumLevels-1:0];
      RegPersistMs:    level_cfg.persist_ms     = data;
      default: ;
    endcase
  endtask

  // Load a full register set, with a stray write to the unused index
  task automatic load_cfg(input plm_cfg_t c, input logic [CfgDataW-1:0] stray);
    write_reg(RegLowerLimit,   c.lower_limit);
    write_reg(RegLowerWarning, c.lower_warning);
    write_reg(RegUpperWarning, c.upper_warning);
    write_reg(RegUpperLimit,   c.upper_limit);
    write_reg(RegLevelEnable,  {{(CfgDataW-NumLevels){1'b1}}, c.level_enable});
    write_reg(RegTestOnlyMask, {{(CfgDataW-NumLevels){1'b0}}, c.test_only_mask});
    write_reg(RegPersistMs,    c.persist_ms);
    write_reg(RegUnused,       stray);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_sample(input logic [LevelW-1:0] value, input logic testing,
                              input logic [TimeW-1:0] stamp);
    pending_samples.push_back('{value, testing, stamp});
  endtask

  // Hold until every queued item has been taken and every result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || smp.valid || due_masks.size() != 0);
  endtask

  // Queue bursts that sit near one level, mixed with noise and time jumps
  task automatic queue_bursts(input int unsigned count);
    int unsigned k;
    int unsigned left;
    int unsigned r;
    int unsigned step_max;
    int          v;
    logic [LevelW-1:0] thr;
    left     = 0;
    thr      = '0;
    step_max = level_cfg.persist_ms / 4 + 2;
    for (k = 0; k < count; k++) begin
      if (left == 0) begin
        left = $urandom_range(3, 12);
        case ($urandom_range(0, 3))
          0: thr = level_cfg.lower_limit;
          1: thr = level_cfg.lower_warning;
          2: thr = level_cfg.upper_warning;
          default: thr = level_cfg.upper_limit;
        endcase
      end
      left--;
      r = $urandom_range(0, 99);
      if (r < 70) v = int'(thr) + int'($urandom_range(0, 4)) - 2;
      else if (r < 90) v = int'($urandom_range(0, 65535));
      else v = r[0] ? 0 : 65535;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      r = $urandom_range(0, 99);
      if (r < 88) stamp_ms = stamp_ms + $urandom_range(0, step_max);
      else if (r < 94) stamp_ms = stamp_ms - $urandom_range(1, 100);
      else stamp_ms = $urandom();
      queue_sample(v[LevelW-1:0], $urandom_range(0, 99) < 85, stamp_ms);
    end
  endtask

  // Stimulus sequence
  initial begin
    plm_cfg_t c;
    int unsigned lw;
    int unsigned uw;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    smp.valid        = 1'b0;
    smp.sample_value = '0;
    smp.test_running = 1'b0;
    smp.now_ms       = '0;
    res.ready        = 1'b0;
    fault_count      = 0;
    stamp_ms         = '0;
    send_idle_pct    = 26;
    recv_idle_pct    = 68;
    level_cfg        = '{RstLowerLimit, RstLowerWarning, RstUpperWarning, RstUpperLimit,
                         RstLevelEnable, RstTestOnlyMask, RstPersistMs};
    armed_now        = '0;
    for (int i = 0; i < NumLevels; i++) armed_at[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: arm, persistence boundary, repeats, gating, wrap
    queue_sample(16'd0,     1'b1, 32'd0);
    queue_sample(16'd0,     1'b1, 32'd249);
    queue_sample(16'd0,     1'b1, 32'd250);
    queue_sample(16'd0,     1'b1, 32'd1000);
    queue_sample(16'd6000,  1'b1, 32'd1100);
    queue_sample(16'd6001,  1'b1, 32'd1200);
    queue_sample(16'd7000,  1'b0, 32'd1300);
    queue_sample(16'd65535, 1'b1, 32'd2000);
    queue_sample(16'd65535, 1'b1, 32'd1999);
    queue_sample(16'd14000, 1'b1, 32'd5000);
    queue_sample(16'd13999, 1'b1, 32'd5001);
    queue_sample(16'd13000, 1'b1, 32'd5002);
    queue_sample(16'd12999, 1'b1, 32'd5003);
    queue_sample(16'd10000, 1'b1, 32'hFFFF_FFFF);
    queue_sample(16'd0,     1'b1, 32'hFFFF_FF00);
    queue_sample(16'd0,     1'b1, 32'h0000_0010);
    wait_drained();

    // Zero delay, no test gating, one level disabled
    c = '{RstLowerLimit, RstLowerWarning, RstUpperWarning, RstUpperLimit,
          4'b1011, 4'b0000, 16'd0};
    load_cfg(c, 16'hFFFF);
    queue_sample(16'd0,     1'b0, 32'd7);
    queue_sample(16'd0,     1'b0, 32'd7);
    queue_sample(16'd65535, 1'b0, 32'd7);
    queue_sample(16'd65535, 1'b0, 32'd7);
    queue_sample(16'd40000, 1'b1, 32'd8);
    wait_drained();

    // Random phases, each with its own register set
    for (int p = 0; p < 9; p++) begin
      send_idle_pct = (p < 3) ? 26 : (p < 6) ? 68 : 0;
      recv_idle_pct = (p < 3) ? 68 : (p < 6) ? 26 : 0;
      case (p)
        0: c = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 4'hF, 4'h0, 16'd0};
        1: c = '{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 4'hF, 4'hF, 16'hFFFF};
        default: begin
          c.lower_limit = LevelW'($urandom_range(0, 30000));
          lw            = c.lower_limit + $urandom_range(0, 5000);
          uw            = lw + $urandom_range(0, 20000);
          c.lower_warning = LevelW'(lw);
          c.upper_warning = LevelW'(uw);
          c.upper_limit   = LevelW'(uw + $urandom_range(0, 5000));
          c.level_enable   = (p == 2) ? 4'h0 : NumLevels'($urandom_range(0, 15));
          c.test_only_mask = NumLevels'($urandom_range(0, 15));
          c.persist_ms     = ($urandom_range(0, 3) == 0) ? LevelW'($urandom_range(0, 65535))
                                                         : LevelW'($urandom_range(0, 40));
        end
      endcase
      load_cfg(c, CfgDataW'($urandom_range(0, 65535)));
      queue_bursts(66);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("persistent_limit_monitor_tb: clean");
    end else begin
      $display("persistent_limit_monitor_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("persistent_limit_monitor_tb: errors");
    $finish;
  end

endmodule
